@@ design/modbus_rtu_register_master_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU register master
// Shared concurrent check forms. Every check is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REGISTER_MASTER_UNIT_ASSERT_SVH
`define MODBUS_RTU_REGISTER_MASTER_UNIT_ASSERT_SVH

// Condition holds at every clock edge.
`define MRM_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("mrm check failed: invariant");

// Antecedent implies consequent in the same cycle.
`define MRM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrm check failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define MRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrm check failed: next-cycle implication");

`endif

@@ design/mrm_pkg.sv @@
// ----------------------------------------------------------------------------
// mrm_pkg
// Types, codes and helper functions of the Modbus RTU register master.
// ----------------------------------------------------------------------------
package mrm_pkg;

   // Input item codes
   localparam logic [2:0] FUNC_RD_INPUT   = 3'd0;
   localparam logic [2:0] FUNC_RD_HOLDING = 3'd1;
   localparam logic [2:0] FUNC_WR_HOLDING = 3'd2;
   localparam logic [2:0] FUNC_RX_BYTE    = 3'd3;
   localparam logic [2:0] FUNC_TICK       = 3'd4;

   // Pending operation (low bits of the command code)
   localparam logic [1:0] OP_RD_INPUT   = 2'd0;
   localparam logic [1:0] OP_RD_HOLDING = 2'd1;
   localparam logic [1:0] OP_WR_HOLDING = 2'd2;

   // Modbus function codes on the wire
   localparam logic [7:0] MB_FC_RD_INPUT   = 8'h04;
   localparam logic [7:0] MB_FC_RD_HOLDING = 8'h03;
   localparam logic [7:0] MB_FC_WR_SINGLE  = 8'h06;

   // Completion status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TIMEOUT   = 3'd1;
   localparam logic [2:0] ST_BAD_COUNT = 3'd2;
   localparam logic [2:0] ST_BAD_CRC   = 3'd3;
   localparam logic [2:0] ST_ECHO_BAD  = 3'd4;

   // Result kinds
   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // CRC-16/Modbus
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] ERR_VALUE = 16'hFFFF;

   // Configuration registers
   localparam logic       CSR_IDX_SLAVE    = 1'b0;
   localparam logic       CSR_IDX_TIMEOUT  = 1'b1;
   localparam int         CSR_ADDR_W       = 3;
   localparam logic [7:0] SLAVE_ADDR_RESET = 8'hFE;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd100;

   // Job queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One unit of work handed from front to back: a request to send or a completion.
   typedef struct packed {
      logic        done;
      logic [1:0]  op;
      logic [7:0]  slave;
      logic [7:0]  reg_addr;
      logic [15:0] value;
      logic [2:0]  status;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_LOAD,
      BACK_SEND
   } back_state_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] func_code(input logic [1:0] op);
      logic [7:0] fc;
      unique case (op)
         OP_RD_INPUT:   fc = MB_FC_RD_INPUT;
         OP_RD_HOLDING: fc = MB_FC_RD_HOLDING;
         default:       fc = MB_FC_WR_SINGLE;
      endcase
      return fc;
   endfunction

endpackage

@@ design/mrm_channels.sv @@
// ----------------------------------------------------------------------------
// mrm channels
// Valid/ready channel interfaces for command items and result words.
// ----------------------------------------------------------------------------
interface mrm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [7:0]  reg_addr;
   logic [15:0] write_value;
   logic [7:0]  rx_byte;

   modport source (output valid, func, reg_addr, write_value, rx_byte, input ready);
   modport sink   (input valid, func, reg_addr, write_value, rx_byte, output ready);
endinterface

interface mrm_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  tx_byte;
   logic [15:0] reg_value;
   logic [2:0]  status;
   logic        last;

   modport source (output valid, kind, tx_byte, reg_value, status, last, input ready);
   modport sink   (input valid, kind, tx_byte, reg_value, status, last, output ready);
endinterface

@@ design/mrm_front.sv @@
// ----------------------------------------------------------------------------
// mrm_front
// Accepts items, tracks the transaction, checks the response, queues jobs.
// ----------------------------------------------------------------------------
module mrm_front (
   input  logic             clock,
   input  logic             reset,
   mrm_req_if.sink          req_if,
   input  logic [7:0]       slave_address,
   input  logic [15:0]      timeout_ticks,
   input  logic             q_full,
   output logic             q_push,
   output mrm_pkg::job_type q_job
);

   logic        busy_ff, busy_in;
   logic [1:0]  op_ff, op_in;
   logic [3:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] data_ff, data_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [15:0] echo_ff, echo_in;
   logic [15:0] wait_ff, wait_in;

   logic        accept;
   logic        fin;
   logic [2:0]  fin_status;
   logic [15:0] crc_fed;
   logic [15:0] got_crc;
   logic [15:0] wait_inc;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign crc_fed      = mrm_pkg::crc_feed(crc_ff, req_if.rx_byte);
   assign got_crc      = {req_if.rx_byte, crc_lo_ff};
   assign wait_inc     = (wait_ff == 16'hFFFF) ? wait_ff : wait_ff + 16'd1;

   always_comb begin
      busy_in    = busy_ff;
      op_in      = op_ff;
      idx_in     = idx_ff;
      crc_in     = crc_ff;
      count_in   = count_ff;
      data_in    = data_ff;
      crc_lo_in  = crc_lo_ff;
      echo_in    = echo_ff;
      wait_in    = wait_ff;
      fin        = 1'b0;
      fin_status = mrm_pkg::ST_OK;
      q_push     = 1'b0;
      q_job      = '0;

      if (accept) begin
         unique case (req_if.func) inside
            mrm_pkg::FUNC_RD_INPUT, mrm_pkg::FUNC_RD_HOLDING, mrm_pkg::FUNC_WR_HOLDING: begin
               if (!busy_ff) begin
                  q_push         = 1'b1;
                  q_job.done     = 1'b0;
                  q_job.op       = req_if.func[1:0];
                  q_job.slave    = slave_address;
                  q_job.reg_addr = req_if.reg_addr;
                  q_job.value    = req_if.write_value;
                  busy_in   = 1'b1;
                  op_in     = req_if.func[1:0];
                  idx_in    = 4'd0;
                  crc_in    = mrm_pkg::CRC_INIT;
                  count_in  = 8'd0;
                  data_in   = 16'd0;
                  crc_lo_in = 8'd0;
                  echo_in   = (req_if.func == mrm_pkg::FUNC_WR_HOLDING) ?
                              req_if.write_value : 16'd0;
                  wait_in   = 16'd0;
               end
            end
            mrm_pkg::FUNC_RX_BYTE: begin
               if (busy_ff) begin
                  idx_in = idx_ff + 4'd1;
                  if (op_ff != mrm_pkg::OP_WR_HOLDING) begin
                     // Read response: addr, func, count, hi, lo, crc lo, crc hi
                     if (idx_ff < 4'd5) crc_in = crc_fed;
                     if (idx_ff == 4'd2) count_in = req_if.rx_byte;
                     else if (idx_ff == 4'd3) data_in = {req_if.rx_byte, data_ff[7:0]};
                     else if (idx_ff == 4'd4) data_in = {data_ff[15:8], req_if.rx_byte};
                     else if (idx_ff == 4'd5) crc_lo_in = req_if.rx_byte;
                     else if (idx_ff >= 4'd6) begin
                        fin = 1'b1;
                        if (count_ff != 8'd2) fin_status = mrm_pkg::ST_BAD_COUNT;
                        else if (got_crc != crc_ff) fin_status = mrm_pkg::ST_BAD_CRC;
                        else fin_status = mrm_pkg::ST_OK;
                     end
                  end else begin
                     // Write echo: addr, func, reg hi, reg lo, hi, lo, crc lo, crc hi
                     if (idx_ff < 4'd6) crc_in = crc_fed;
                     if (idx_ff == 4'd4) data_in = {req_if.rx_byte, data_ff[7:0]};
                     else if (idx_ff == 4'd5) data_in = {data_ff[15:8], req_if.rx_byte};
                     else if (idx_ff == 4'd6) crc_lo_in = req_if.rx_byte;
                     else if (idx_ff >= 4'd7) begin
                        fin = 1'b1;
                        if (data_ff != echo_ff) fin_status = mrm_pkg::ST_ECHO_BAD;
                        else if (got_crc != crc_ff) fin_status = mrm_pkg::ST_BAD_CRC;
                        else fin_status = mrm_pkg::ST_OK;
                     end
                  end
               end
            end
            mrm_pkg::FUNC_TICK: begin
               if (busy_ff) begin
                  wait_in = wait_inc;
                  if (wait_inc >= timeout_ticks) begin
                     fin        = 1'b1;
                     fin_status = mrm_pkg::ST_TIMEOUT;
                  end
               end
            end
            default: ;
         endcase
      end

      if (fin) begin
         busy_in      = 1'b0;
         idx_in       = 4'd0;
         q_push       = 1'b1;
         q_job.done   = 1'b1;
         q_job.status = fin_status;
         q_job.value  = (fin_status == mrm_pkg::ST_OK) ? data_ff : mrm_pkg::ERR_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         op_ff     <= 2'd0;
         idx_ff    <= 4'd0;
         crc_ff    <= mrm_pkg::CRC_INIT;
         count_ff  <= 8'd0;
         data_ff   <= 16'd0;
         crc_lo_ff <= 8'd0;
         echo_ff   <= 16'd0;
         wait_ff   <= 16'd0;
      end else begin
         busy_ff   <= busy_in;
         op_ff     <= op_in;
         idx_ff    <= idx_in;
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         data_ff   <= data_in;
         crc_lo_ff <= crc_lo_in;
         echo_ff   <= echo_in;
         wait_ff   <= wait_in;
      end
   end

`include "modbus_rtu_register_master_unit_assert.svh"

`MRM_ASSERT_NEXT(a_done_clears_busy, clock, reset, q_push && q_job.done, !busy_ff)
`MRM_ASSERT_ALWAYS(a_rx_index_bound, clock, reset, idx_ff <= 4'd7)

endmodule

@@ design/mrm_queue.sv @@
// ----------------------------------------------------------------------------
// mrm_queue
// Short job queue between the front and the back. A popped job appears on
// pop_job in the cycle after the pop.
// ----------------------------------------------------------------------------
module mrm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mrm_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output mrm_pkg::job_type pop_job,
   output logic             empty
);

   mrm_pkg::job_type            mem [mrm_pkg::QUEUE_DEPTH];
   logic [mrm_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mrm_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mrm_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign full    = (count_ff == (mrm_pkg::QUEUE_AW + 1)'(mrm_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
      if (pop) begin
         pop_job <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`include "modbus_rtu_register_master_unit_assert.svh"

`MRM_ASSERT_IMPLY(a_no_push_when_full, clock, reset, push, !full || pop)

endmodule

@@ design/mrm_back.sv @@
// ----------------------------------------------------------------------------
// mrm_back
// Serializes request frames with their CRC and delivers completion words.
// ----------------------------------------------------------------------------
module mrm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  mrm_pkg::job_type q_job,
   output logic             q_pop,
   mrm_rsp_if.source        rsp_if
);

   mrm_pkg::back_state_type state_ff, state_in;
   mrm_pkg::job_type        job_ff, job_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic [15:0]             crc_ff, crc_in;

   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  tx_ff, tx_in;
   logic [15:0] value_ff, value_in;
   logic [2:0]  status_ff, status_in;
   logic        last_ff, last_in;

   logic        out_free;
   logic [7:0]  frame_byte;
   logic        is_write;

   assign out_free = !valid_ff || rsp_if.ready;
   assign is_write = (job_ff.op == mrm_pkg::OP_WR_HOLDING);

   // Byte of the request frame at the current position.
   always_comb begin
      case (cnt_ff)
         3'd0:    frame_byte = job_ff.slave;
         3'd1:    frame_byte = mrm_pkg::func_code(job_ff.op);
         3'd2:    frame_byte = 8'h00;
         3'd3:    frame_byte = job_ff.reg_addr;
         3'd4:    frame_byte = is_write ? job_ff.value[15:8] : 8'h00;
         3'd5:    frame_byte = is_write ? job_ff.value[7:0]  : 8'h01;
         3'd6:    frame_byte = crc_ff[7:0];
         default: frame_byte = crc_ff[15:8];
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cnt_in    = cnt_ff;
      crc_in    = crc_ff;
      q_pop     = 1'b0;
      valid_in  = out_free ? 1'b0 : valid_ff;
      kind_in   = kind_ff;
      tx_in     = tx_ff;
      value_in  = value_ff;
      status_in = status_ff;
      last_in   = last_ff;

      unique case (state_ff)
         mrm_pkg::BACK_IDLE: begin
            // Pop only with a free output register; the job arrives next cycle.
            if (out_free && !q_empty) begin
               q_pop    = 1'b1;
               state_in = mrm_pkg::BACK_LOAD;
            end
         end
         mrm_pkg::BACK_LOAD: begin
            if (q_job.done) begin
               valid_in  = 1'b1;
               kind_in   = mrm_pkg::KIND_DONE;
               tx_in     = 8'h00;
               value_in  = q_job.value;
               status_in = q_job.status;
               last_in   = 1'b1;
               state_in  = mrm_pkg::BACK_IDLE;
            end else begin
               job_in   = q_job;
               cnt_in   = 3'd0;
               crc_in   = mrm_pkg::CRC_INIT;
               state_in = mrm_pkg::BACK_SEND;
            end
         end
         mrm_pkg::BACK_SEND: begin
            if (out_free) begin
               valid_in  = 1'b1;
               kind_in   = mrm_pkg::KIND_TX;
               tx_in     = frame_byte;
               value_in  = 16'd0;
               status_in = mrm_pkg::ST_OK;
               last_in   = (cnt_ff == 3'd7);
               if (cnt_ff < 3'd6) crc_in = mrm_pkg::crc_feed(crc_ff, frame_byte);
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) state_in = mrm_pkg::BACK_IDLE;
            end
         end
         default: state_in = mrm_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrm_pkg::BACK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      cnt_ff    <= cnt_in;
      crc_ff    <= crc_in;
      kind_ff   <= kind_in;
      tx_ff     <= tx_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.kind      = kind_ff;
   assign rsp_if.tx_byte   = tx_ff;
   assign rsp_if.reg_value = value_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.last      = last_ff;

`include "modbus_rtu_register_master_unit_assert.svh"

`MRM_ASSERT_IMPLY(a_no_pop_while_sending, clock, reset, state_ff == mrm_pkg::BACK_SEND, !q_pop)
`MRM_ASSERT_IMPLY(a_load_output_free, clock, reset, state_ff == mrm_pkg::BACK_LOAD, !valid_ff)

endmodule

@@ design/modbus_rtu_register_master_unit.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_register_master_unit
// Modbus RTU master for a single register: request framing and response check.
// ----------------------------------------------------------------------------
// The block takes one item per clock on the req channel while the job queue
// has room: a read-input, read-holding or write-single command, a received
// bus byte, or a timer tick. An accepted command (only while no transaction
// is open) yields eight transmit words, address through CRC high byte, with
// last set on the eighth; received bytes and ticks of an open transaction
// yield at most one completion word carrying the register value and status.
// A front end tracks the transaction and checks the response in the cycle
// the item arrives; it hands each request or completion as a job to a
// four-entry queue. A back end pops a job, loads it from the queue, then
// emits one frame byte per cycle while the output register is free, folding
// the CRC. Request words pass the queue, its output register, the job
// register and the rsp output register; completions skip the job register.
// req_ready drops only while the job queue is full; rsp words sit in an
// output register, so both sides stall independently. Configuration is an
// APB slave: slave_address at byte 0 and timeout_ticks at byte 4. The user
// must write them only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module modbus_rtu_register_master_unit (
   input  logic        clock,
   input  logic        reset,
   mrm_req_if.sink     req_if,
   mrm_rsp_if.source   rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [mrm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers
   logic [7:0]  slave_ff, slave_in;
   logic [15:0] timeout_ff, timeout_in;
   logic        csr_wr;
   logic        csr_idx;

   // Front to queue, queue to back
   logic             q_push, q_full, q_pop, q_empty;
   mrm_pkg::job_type push_job, pop_job;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   // Register index sits at byte address bit 2; ignore the low byte-lane bits.
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      slave_in   = slave_ff;
      timeout_in = timeout_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            mrm_pkg::CSR_IDX_SLAVE:   slave_in   = csr_pwdata[7:0];
            mrm_pkg::CSR_IDX_TIMEOUT: timeout_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         mrm_pkg::CSR_IDX_SLAVE:   csr_prdata = {24'd0, slave_ff};
         mrm_pkg::CSR_IDX_TIMEOUT: csr_prdata = {16'd0, timeout_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff   <= mrm_pkg::SLAVE_ADDR_RESET;
         timeout_ff <= mrm_pkg::TIMEOUT_RESET;
      end else begin
         slave_ff   <= slave_in;
         timeout_ff <= timeout_in;
      end
   end

   // Accept and classify items, track the open transaction.
   mrm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .slave_address (slave_ff),
      .timeout_ticks (timeout_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (push_job)
   );

   // Hold jobs so the front keeps accepting while the back is busy sending.
   mrm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   // Drain jobs onto the result channel.
   mrm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_job   (pop_job),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule
